// ----- rtl/indexed_min_heap_macros.svh -----
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define IMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define IMH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/imh_pkg.sv -----
package imh_pkg;
    localparam int HEAP_DEPTH_DEF   = 256;
    localparam int HANDLE_COUNT_DEF = 256;
    localparam int KEY_WIDTH_DEF    = 32;
    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 8;
    localparam int SIZE_W   = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_PEEK    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // datapath operations, at most one active at a time
    typedef struct packed {
        logic load;      // latch request, read position map
        logic start;     // decide command from map and size
        logic rd1;       // root or changed slot arrives
        logic rd2;       // last slot arrives
        logic up_a;      // read parent
        logic up_b;      // compare with parent, move or settle
        logic dn_a;      // read left child
        logic dn_b;      // latch left child, read right child
        logic dn_c;      // pick smallest, move or settle
    } t_cmd_bus;

    typedef struct packed {
        logic done_now;  // command needs no more work
        logic need_read; // command reads a slot first
        logic need_last; // extract reads the last slot
        logic sift_up;   // sift direction
        logic sift_end;  // sift finished
    } t_sts_bus;
endpackage

// ----- rtl/imh_ram.sv -----
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/imh_datapath.sv -----
`include "indexed_min_heap_macros.svh"
module imh_datapath #(
    parameter int HEAP_DEPTH   = imh_pkg::HEAP_DEPTH_DEF,
    parameter int HANDLE_COUNT = imh_pkg::HANDLE_COUNT_DEF,
    parameter int KEY_WIDTH    = imh_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  imh_pkg::t_cmd_bus             i_cmd,
    output imh_pkg::t_sts_bus             o_sts,
    input  logic [imh_pkg::SIZE_W-1:0]    i_capacity,
    input  logic [imh_pkg::CMD_W-1:0]     i_command,
    input  logic [imh_pkg::HANDLE_W-1:0]  i_handle,
    input  logic signed [KEY_WIDTH-1:0]   i_key,
    output logic [imh_pkg::STATUS_W-1:0]  o_status,
    output logic [imh_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic signed [KEY_WIDTH-1:0]   o_out_key,
    output logic [imh_pkg::SIZE_W-1:0]    o_heap_size
);
    localparam int PW = $clog2(HEAP_DEPTH + 1);   // slot number width, 1..DEPTH
    localparam int AW = $clog2(HEAP_DEPTH);       // ram address, slot-1
    localparam int HW = $clog2(HANDLE_COUNT);
    localparam int EW = KEY_WIDTH + HW;

    // slot entry memory and position map memory
    logic          w_s_we;
    logic [AW-1:0] w_s_waddr, w_s_raddr;
    logic [EW-1:0] w_s_wdata, w_s_rdata;
    logic          w_p_we;
    logic [HW-1:0] w_p_waddr, w_p_raddr;
    logic [PW-1:0] w_p_wdata, w_p_rdata;

    imh_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_slots (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_waddr), .i_wdata(w_s_wdata),
        .i_raddr(w_s_raddr), .o_rdata(w_s_rdata));
    imh_ram #(.WIDTH(PW), .DEPTH(HANDLE_COUNT)) u_pmap (
        .i_clk(i_clk), .i_we(w_p_we), .i_waddr(w_p_waddr), .i_wdata(w_p_wdata),
        .i_raddr(w_p_raddr), .o_rdata(w_p_rdata));

    // valid bits for position map entries
    logic [HANDLE_COUNT-1:0] r_pvalid, n_pvalid;

    logic [imh_pkg::CMD_W-1:0]    r_cmd;
    logic [imh_pkg::HANDLE_W-1:0] r_hin;
    logic [KEY_WIDTH-1:0]         r_kin;
    logic                         r_hbad;
    logic [PW-1:0]                r_cnt, n_cnt;
    logic [PW-1:0]                r_cur;
    logic [KEY_WIDTH-1:0]         r_ck;    // moving entry key
    logic [HW-1:0]                r_ch;    // moving entry handle
    logic [KEY_WIDTH-1:0]         r_bk;    // left child key
    logic [HW-1:0]                r_bh;
    logic [imh_pkg::STATUS_W-1:0] r_status;
    logic [imh_pkg::HANDLE_W-1:0] r_oh;
    logic [KEY_WIDTH-1:0]         r_ok;

    logic [HW-1:0]        w_hidx;
    logic [PW-1:0]        w_pos;
    logic                 w_present;
    logic [31:0]          w_cap32;
    logic [31:0]          w_limit;
    logic                 w_full;
    logic                 w_ins_chg;
    logic [PW:0]          w_left, w_right;
    logic [KEY_WIDTH-1:0] w_rk;
    logic [HW-1:0]        w_rh;
    logic [KEY_WIDTH-1:0] w_bestk;
    logic                 w_upswap;
    logic                 w_lsel;
    logic                 w_rsel;

    assign w_rk      = w_s_rdata[EW-1:HW];
    assign w_rh      = w_s_rdata[HW-1:0];
    assign w_hidx    = HW'(r_hin);
    assign w_pos     = w_p_rdata;
    assign w_present = !r_hbad && r_pvalid[w_hidx] && (w_pos != '0) && (w_pos <= r_cnt);
    assign w_cap32   = 32'(i_capacity);
    assign w_limit   = (w_cap32 > 32'(HEAP_DEPTH)) ? 32'(HEAP_DEPTH) : w_cap32;
    assign w_full    = (32'(r_cnt) >= w_limit);
    assign w_ins_chg = (r_cmd == imh_pkg::CMD_INSERT) || (r_cmd == imh_pkg::CMD_CHANGE);
    assign w_left    = {r_cur, 1'b0};
    assign w_right   = {r_cur, 1'b1};
    assign w_upswap  = $signed(r_ck) < $signed(w_rk);
    assign w_lsel    = $signed(r_bk) < $signed(r_ck);
    assign w_bestk   = w_lsel ? r_bk : r_ck;
    assign w_rsel    = (w_right <= {1'b0, r_cnt}) && ($signed(w_rk) < $signed(w_bestk));
    assign w_p_raddr = HW'(i_handle);
    assign w_p_wdata = r_cur;

    // sift control status
    always_comb begin
        o_sts = '0;
        if (i_cmd.start) begin
            if (w_ins_chg) begin
                o_sts.need_read = w_present;
                o_sts.done_now  = r_hbad || (!w_present &&
                    ((r_cmd == imh_pkg::CMD_CHANGE) || w_full));
            end else begin
                o_sts.need_read = (r_cnt != '0);
                o_sts.done_now  = (r_cnt == '0);
            end
        end
        if (i_cmd.rd1) begin
            o_sts.done_now  = (r_cmd == imh_pkg::CMD_PEEK) ||
                              ((r_cmd == imh_pkg::CMD_EXTRACT) && (r_cnt == '0));
            o_sts.need_last = (r_cmd == imh_pkg::CMD_EXTRACT) && (r_cnt != '0);
            o_sts.sift_up   = w_upswap;
        end
        o_sts.sift_end = (i_cmd.up_a && (r_cur == PW'(1)))
                      || (i_cmd.up_b && !w_upswap)
                      || (i_cmd.dn_a && (w_left > {1'b0, r_cnt}))
                      || (i_cmd.dn_c && !w_lsel && !w_rsel);
    end

    always_comb begin
        w_s_raddr = AW'(w_left - 1'b1);
        if (i_cmd.start) begin
            w_s_raddr = w_ins_chg ? AW'(w_pos - 1'b1) : '0;
        end else if (i_cmd.rd1) begin
            w_s_raddr = AW'(r_cnt);
        end else if (i_cmd.up_a) begin
            w_s_raddr = AW'((r_cur >> 1) - 1'b1);
        end else if (i_cmd.dn_b) begin
            w_s_raddr = AW'(w_right - 1'b1);
        end
    end

    always_comb begin
        w_s_we    = 1'b0;
        w_s_waddr = AW'(r_cur - 1'b1);
        w_s_wdata = {r_ck, r_ch};
        w_p_we    = 1'b0;
        w_p_waddr = r_ch;
        n_pvalid  = r_pvalid;
        if (o_sts.sift_end) begin
            // settle moving entry at cursor
            w_s_we = 1'b1;
            w_p_we = 1'b1;
            n_pvalid[r_ch] = 1'b1;
        end else if (i_cmd.up_b) begin
            // parent moves down into cursor slot
            w_s_we    = 1'b1;
            w_s_wdata = {w_rk, w_rh};
            w_p_we    = 1'b1;
            w_p_waddr = w_rh;
        end else if (i_cmd.dn_c) begin
            // smaller child moves up into cursor slot
            w_s_we = 1'b1;
            w_p_we = 1'b1;
            if (w_rsel) begin
                w_s_wdata = {w_rk, w_rh};
                w_p_waddr = w_rh;
            end else begin
                w_s_wdata = {r_bk, r_bh};
                w_p_waddr = r_bh;
            end
        end
        if (i_cmd.rd1 && (r_cmd == imh_pkg::CMD_EXTRACT)) begin
            n_pvalid[w_rh] = 1'b0;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.start) begin
            if ((r_cmd == imh_pkg::CMD_INSERT) && !r_hbad && !w_present && !w_full) begin
                n_cnt = r_cnt + 1'b1;
            end else if ((r_cmd == imh_pkg::CMD_EXTRACT) && (r_cnt != '0)) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            r_cnt    <= '0;
        end else begin
            r_pvalid <= n_pvalid;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_hin  <= i_handle;
            r_kin  <= i_key;
            r_hbad <= (32'(i_handle) >= 32'(HANDLE_COUNT));
        end
        if (i_cmd.start) begin
            r_status <= imh_pkg::ST_OK;
            r_oh     <= r_hin;
            r_ok     <= r_kin;
            r_ch     <= w_hidx;
            r_ck     <= r_kin;
            if (w_ins_chg) begin
                if (r_hbad || (!w_present && r_cmd == imh_pkg::CMD_CHANGE)) begin
                    r_status <= imh_pkg::ST_NOT_FOUND;
                end else if (!w_present && w_full) begin
                    r_status <= imh_pkg::ST_FULL;
                end
                r_cur <= w_present ? w_pos : r_cnt + 1'b1;
            end else begin
                r_cur <= PW'(1);
                if (r_cnt == '0) begin
                    r_status <= imh_pkg::ST_EMPTY;
                    r_oh     <= '0;
                    r_ok     <= '0;
                end
            end
        end
        if (i_cmd.rd1 && !w_ins_chg) begin
            r_oh <= imh_pkg::HANDLE_W'(w_rh);
            r_ok <= w_rk;
        end
        if (i_cmd.rd2) begin
            r_ck <= w_rk;
            r_ch <= w_rh;
        end
        if (i_cmd.dn_b) begin
            r_bk <= w_rk;
            r_bh <= w_rh;
        end
        if (i_cmd.up_b && !o_sts.sift_end) begin
            r_cur <= r_cur >> 1;
        end
        if (i_cmd.dn_c && !o_sts.sift_end) begin
            r_cur <= w_rsel ? PW'(w_right) : PW'(w_left);
        end
    end

    assign o_status     = r_status;
    assign o_out_handle = r_oh;
    assign o_out_key    = r_ok;
    assign o_heap_size  = imh_pkg::SIZE_W'(r_cnt);

    `IMH_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= PW'(HEAP_DEPTH))
    `IMH_ASSERT_NXT(a_cnt_step, i_clk, i_rst_n, !i_cmd.start, r_cnt == $past(r_cnt))
    `IMH_ASSERT_IMP(a_one_op, i_clk, i_rst_n, 1'b1, $onehot0(i_cmd))
endmodule

// ----- rtl/indexed_min_heap.sv -----
// channel   | direction | handshake
// request   | in        | i_valid / o_ready
// result    | out       | o_valid / i_ready
// capacity  | in        | i_cfg_we, no wait
// decode runs in S_DEC; reading the root or a changed entry adds S_RD1, the last entry S_RD2
// each level checked goes through S_UP_A, S_UP_B going up and S_DN_A, S_DN_B, S_DN_C going down
// a sift ends in S_UP_A at the root or in S_DN_A at a leaf; the slot memory read is registered
// reset is synchronous active low and clears size, map valid bits and control
// one request is worked at a time; the result is held until taken
module indexed_min_heap #(
    parameter int HEAP_DEPTH   = imh_pkg::HEAP_DEPTH_DEF,
    parameter int HANDLE_COUNT = imh_pkg::HANDLE_COUNT_DEF,
    parameter int KEY_WIDTH    = imh_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [imh_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [imh_pkg::CMD_W-1:0]     i_command,
    input  logic [imh_pkg::HANDLE_W-1:0]  i_handle,
    input  logic signed [KEY_WIDTH-1:0]   i_key,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [imh_pkg::STATUS_W-1:0]  o_status,
    output logic [imh_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic signed [KEY_WIDTH-1:0]   o_out_key,
    output logic [imh_pkg::SIZE_W-1:0]    o_heap_size
);
    logic [imh_pkg::SIZE_W-1:0] r_capacity;
    imh_pkg::t_cmd_bus w_cmd;
    imh_pkg::t_sts_bus w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= imh_pkg::SIZE_W'(HEAP_DEPTH);
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    imh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(w_cmd), .i_sts(w_sts));

    imh_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .HANDLE_COUNT(HANDLE_COUNT),
                   .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_capacity(r_capacity), .i_command(i_command), .i_handle(i_handle),
        .i_key(i_key), .o_status(o_status), .o_out_handle(o_out_handle),
        .o_out_key(o_out_key), .o_heap_size(o_heap_size));
endmodule

module imh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output imh_pkg::t_cmd_bus o_cmd,
    input  imh_pkg::t_sts_bus i_sts
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DEC  = 10'b00_0000_0010,
        S_RD1  = 10'b00_0000_0100,
        S_RD2  = 10'b00_0000_1000,
        S_UP_A = 10'b00_0001_0000,
        S_UP_B = 10'b00_0010_0000,
        S_DN_A = 10'b00_0100_0000,
        S_DN_B = 10'b00_1000_0000,
        S_DN_C = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_sts.done_now) begin
                    n_state = S_OUT;
                end else if (i_sts.need_read) begin
                    n_state = S_RD1;
                end else begin
                    n_state = S_UP_A;
                end
            end
            S_RD1: begin
                priority if (i_sts.done_now) begin
                    n_state = S_OUT;
                end else if (i_sts.need_last) begin
                    n_state = S_RD2;
                end else if (i_sts.sift_up) begin
                    n_state = S_UP_A;
                end else begin
                    n_state = S_DN_A;
                end
            end
            S_RD2: begin
                n_state = S_DN_A;
            end
            S_UP_A: begin
                n_state = i_sts.sift_end ? S_OUT : S_UP_B;
            end
            S_UP_B: begin
                n_state = i_sts.sift_end ? S_OUT : S_UP_A;
            end
            S_DN_A: begin
                n_state = i_sts.sift_end ? S_OUT : S_DN_B;
            end
            S_DN_B: begin
                n_state = S_DN_C;
            end
            S_DN_C: begin
                n_state = i_sts.sift_end ? S_OUT : S_DN_A;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_valid;
        o_cmd.start = (r_state == S_DEC);
        o_cmd.rd1   = (r_state == S_RD1);
        o_cmd.rd2   = (r_state == S_RD2);
        o_cmd.up_a  = (r_state == S_UP_A);
        o_cmd.up_b  = (r_state == S_UP_B);
        o_cmd.dn_a  = (r_state == S_DN_A);
        o_cmd.dn_b  = (r_state == S_DN_B);
        o_cmd.dn_c  = (r_state == S_DN_C);
    end
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import imh_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] handle;
        logic [31:0]         key;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [31:0]         key;
        logic [SIZE_W-1:0]   size;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [SIZE_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_command;
    logic [HANDLE_W-1:0]  i_handle;
    logic signed [31:0]   i_key;
    logic                 o_valid;
    logic                 i_ready;
    logic [STATUS_W-1:0]  o_status;
    logic [HANDLE_W-1:0]  o_out_handle;
    logic signed [31:0]   o_out_key;
    logic [SIZE_W-1:0]    o_heap_size;

    indexed_min_heap DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_handle(i_handle), .i_key(i_key), .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_out_handle(o_out_handle), .o_out_key(o_out_key),
        .o_heap_size(o_heap_size)
    );

    // shadow heap
    logic signed [31:0]  hkey [1:256];
    logic [7:0]          hhandle [1:256];
    logic [8:0]          hpos [0:255];
    int                  hcount;
    int                  hcap;

    t_request  pending_requests[$];
    t_answer   expected_answers[$];
    int        errors;
    bit        idle_enable;
    bit        stall_enable;

    // request taken at the last rising edge
    logic o_ready_seen;

    function automatic void swap_entries(int a, int b);
        logic signed [31:0] k;
        logic [7:0] h;
        k = hkey[a]; h = hhandle[a];
        hkey[a] = hkey[b]; hhandle[a] = hhandle[b];
        hkey[b] = k; hhandle[b] = h;
        hpos[hhandle[a]] = SIZE_W'(a);
        hpos[hhandle[b]] = SIZE_W'(b);
    endfunction

    function automatic void sift_up(int i);
        while (i > 1 && hkey[i] < hkey[i/2]) begin
            swap_entries(i, i/2);
            i = i / 2;
        end
    endfunction

    function automatic void sift_down(int i);
        int m;
        forever begin
            m = i;
            if (2*i <= hcount && hkey[2*i] < hkey[m]) m = 2*i;
            if (2*i+1 <= hcount && hkey[2*i+1] < hkey[m]) m = 2*i+1;
            if (m == i) return;
            swap_entries(i, m);
            i = m;
        end
    endfunction

    function automatic t_answer heap_apply(t_request r);
        t_answer a;
        int pos;
        int lim;
        logic signed [31:0] old;
        a.status = ST_OK; a.handle = r.handle; a.key = r.key;
        lim = hcap > 256 ? 256 : hcap;
        if (r.command == CMD_INSERT || r.command == CMD_CHANGE) begin
            pos = hpos[r.handle];
            if (pos >= 1 && pos <= hcount) begin
                old = hkey[pos];
                hkey[pos] = r.key;
                if (old < $signed(r.key)) sift_down(pos);
                else if ($signed(r.key) < old) sift_up(pos);
            end else if (r.command == CMD_CHANGE) begin
                a.status = ST_NOT_FOUND;
            end else if (hcount >= lim) begin
                a.status = ST_FULL;
            end else begin
                hcount++;
                hkey[hcount] = r.key;
                hhandle[hcount] = r.handle;
                hpos[r.handle] = SIZE_W'(hcount);
                sift_up(hcount);
            end
        end else if (hcount == 0) begin
            a.status = ST_EMPTY; a.handle = '0; a.key = '0;
        end else begin
            a.handle = hhandle[1];
            a.key = hkey[1];
            if (r.command == CMD_EXTRACT) begin
                hpos[hhandle[1]] = 0;
                if (hcount > 1) begin
                    hkey[1] = hkey[hcount];
                    hhandle[1] = hhandle[hcount];
                    hpos[hhandle[1]] = 1;
                    hcount--;
                    sift_down(1);
                end else begin
                    hcount = 0;
                end
            end
        end
        a.size = SIZE_W'(hcount);
        return a;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!(i_valid && !o_ready_seen)) begin
            if (pending_requests.size() > 0 && !(idle_enable && $urandom_range(99) < 35)) begin
                t_request r;
                r = pending_requests.pop_front();
                i_command <= r.command;
                i_handle <= r.handle;
                i_key <= r.key;
                i_valid <= 1;
                expected_answers.push_back(heap_apply(r));
            end else begin
                i_valid <= 0;
            end
        end
        i_ready <= !(stall_enable && $urandom_range(99) < 35);
    end

    always @(posedge i_clk) o_ready_seen <= i_valid && o_ready ? 1'b1 : 1'b0;

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_answer got;
            t_answer exp;
            got = '{o_status, o_out_handle, o_out_key, o_heap_size};
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp = expected_answers.pop_front();
                if (got !== exp) begin
                    $display("%0t: expected st %0d h %0d k %h n %0d, got st %0d h %0d k %h n %0d",
                        $time, exp.status, exp.handle, exp.key, exp.size,
                        got.status, got.handle, got.key, got.size);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request make_request(t_cmd c, int h, logic [31:0] k);
        t_request r;
        r.command = c; r.handle = HANDLE_W'(h); r.key = k;
        return r;
    endfunction

    task automatic drain();
        while (pending_requests.size() > 0 || expected_answers.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_capacity(int c);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_data <= SIZE_W'(c);
        @(negedge i_clk);
        i_cfg_we <= 0;
        hcap = c;
    endtask

    task automatic random_phase(int n, int hrange);
        int c;
        repeat (n) begin
            c = $urandom_range(99);
            if (c < 40)
                pending_requests.push_back(make_request(CMD_INSERT,
                    $urandom_range(hrange), rand_key()));
            else if (c < 65)
                pending_requests.push_back(make_request(CMD_EXTRACT, $urandom, $urandom));
            else if (c < 88)
                pending_requests.push_back(make_request(CMD_CHANGE,
                    $urandom_range(hrange), rand_key()));
            else
                pending_requests.push_back(make_request(CMD_PEEK, $urandom, $urandom));
        end
    endtask

    initial begin
        errors = 0;
        hcount = 0; hcap = 256;
        for (int i = 0; i < 256; i++) hpos[i] = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_data = 0; i_valid = 0; i_ready = 0;
        i_command = CMD_PEEK; i_handle = 0; i_key = 0;
        idle_enable = 0; stall_enable = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed
        pending_requests.push_back(make_request(CMD_EXTRACT, 0, 0));
        pending_requests.push_back(make_request(CMD_PEEK, 0, 0));
        pending_requests.push_back(make_request(CMD_CHANGE, 5, 1));
        pending_requests.push_back(make_request(CMD_INSERT, 255, 32'h7fff_ffff));
        pending_requests.push_back(make_request(CMD_INSERT, 0, 32'h8000_0000));
        pending_requests.push_back(make_request(CMD_INSERT, 7, 32'h0001_0000));
        pending_requests.push_back(make_request(CMD_INSERT, 9, 32'h0001_0000));
        pending_requests.push_back(make_request(CMD_PEEK, 0, 0));
        pending_requests.push_back(make_request(CMD_CHANGE, 0, 32'h7fff_fff0));
        pending_requests.push_back(make_request(CMD_CHANGE, 255, 32'hffff_0000));
        pending_requests.push_back(make_request(CMD_CHANGE, 7, 32'h0001_0000));
        pending_requests.push_back(make_request(CMD_INSERT, 9, 32'h8000_0001));
        for (int i = 0; i < 5; i++) pending_requests.push_back(make_request(CMD_EXTRACT, 0, 0));
        drain();
        write_capacity(0);
        pending_requests.push_back(make_request(CMD_INSERT, 3, 1));
        drain();
        write_capacity(2);
        pending_requests.push_back(make_request(CMD_INSERT, 3, 5));
        pending_requests.push_back(make_request(CMD_INSERT, 4, 6));
        pending_requests.push_back(make_request(CMD_INSERT, 5, 7));
        pending_requests.push_back(make_request(CMD_INSERT, 4, 1));
        drain();

        // random
        idle_enable = 1; stall_enable = 1;
        write_capacity(1);   random_phase(100, 7);   drain();
        write_capacity(511); random_phase(450, 255); drain();
        write_capacity(5);   random_phase(150, 15);  drain();
        idle_enable = 0; stall_enable = 0;
        write_capacity(256); random_phase(300, 255); drain();
        idle_enable = 1; stall_enable = 1;
        write_capacity(40);  random_phase(550, 63);  drain();

        if (errors == 0 && expected_answers.size() == 0)
            $display("indexed_min_heap: match");
        else
            $display("indexed_min_heap: mismatch");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("indexed_min_heap: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/imh_datapath.sv
rtl/indexed_min_heap.sv
test/testbench.sv
